// ----- rtl/core/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared constants for the binary32 adder
// Format widths and derived sizes.
// ----------------------------------------------------------------------------
package fpa_pkg;
    localparam int EXP_WIDTH  = 8;
    localparam int FRAC_WIDTH = 23;
    localparam int FMT_WIDTH  = 1 + EXP_WIDTH + FRAC_WIDTH;
    localparam int MAG_WIDTH  = FRAC_WIDTH + 5;   // hidden + frac + GRS + carry
    localparam int LZ_WIDTH   = $clog2(MAG_WIDTH + 1);
endpackage
`default_nettype wire

// ----- rtl/core/fp32_adder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: operands are registered on accept, then the sum is registered (input reg, result reg).
// Throughput: one item per cycle unless out_ready stalls a held result; the result register is refilled as it drains.
// Reset: rst_n asynchronous, active low; clears both valid flags only.
// ----------------------------------------------------------------------------
// fp32_adder: IEEE binary32 adder
// Round to nearest even, subnormals flushed to zero.
// ----------------------------------------------------------------------------
module fp32_adder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fpa_pkg::FMT_WIDTH-1:0] operand_a,
    input  wire logic [fpa_pkg::FMT_WIDTH-1:0] operand_b,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fpa_pkg::FMT_WIDTH-1:0]      sum
);
    import fpa_pkg::*;

    localparam logic [EXP_WIDTH-1:0]  EMAX  = '1;
    localparam logic [FRAC_WIDTH-1:0] FONES = '1;
    localparam int GRS = MAG_WIDTH - 1;   // carry bit index

    logic                 a_valid_reg;
    logic [FMT_WIDTH-1:0] a_reg, b_reg;
    logic                 o_valid_reg;
    logic [FMT_WIDTH-1:0] o_reg;
    logic [FMT_WIDTH-1:0] res_next;
    logic                 adv;

    assign adv       = !o_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || adv;
    assign out_valid = o_valid_reg;
    assign sum       = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (adv)
                o_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (adv && a_valid_reg)
            o_reg <= res_next;
    end

    always_comb
    begin
        logic                  sa, sb, xs, ys;
        logic [EXP_WIDTH-1:0]  ea, eb, xe, ye, dexp;
        logic [FRAC_WIDTH-1:0] fa, fb;
        logic [FRAC_WIDTH:0]   ma, mb, mx, my;
        logic [MAG_WIDTH-1:0]  xm, ym, ysh, mag, nm;
        logic                  sticky, rnd;
        logic [LZ_WIDTH-1:0]   top, lsh;
        logic                  found;
        logic [FRAC_WIDTH+1:0] mant;
        logic signed [EXP_WIDTH+2:0] ex;
        int unsigned           d;

        sa = a_reg[FMT_WIDTH-1];
        sb = b_reg[FMT_WIDTH-1];
        ea = a_reg[FMT_WIDTH-2:FRAC_WIDTH];
        eb = b_reg[FMT_WIDTH-2:FRAC_WIDTH];
        fa = a_reg[FRAC_WIDTH-1:0];
        fb = b_reg[FRAC_WIDTH-1:0];
        ma = {1'b1, fa};
        mb = {1'b1, fb};
        if (ea > eb || (ea == eb && ma >= mb))
        begin
            xe = ea; ye = eb; xs = sa; ys = sb; mx = ma; my = mb;
        end
        else
        begin
            xe = eb; ye = ea; xs = sb; ys = sa; mx = mb; my = ma;
        end
        dexp = xe - ye;
        d = (dexp > EXP_WIDTH'(FRAC_WIDTH + 4)) ? FRAC_WIDTH + 4 : 32'(dexp);
        xm  = {1'b0, mx, 3'b000};
        ym  = {1'b0, my, 3'b000};
        sticky = |(ym & ((MAG_WIDTH'(1) << d) - MAG_WIDTH'(1)));
        ysh = (ym >> d) | MAG_WIDTH'(sticky);
        mag = (xs == ys) ? xm + ysh : xm - ysh;

        top = '0;
        found = 1'b0;
        for (int i = MAG_WIDTH - 1; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                top = LZ_WIDTH'(i);
                found = 1'b1;
            end
        end
        ex = (EXP_WIDTH+3)'(xe);
        nm = mag;
        lsh = '0;
        if (top == LZ_WIDTH'(GRS))
        begin
            nm = (mag >> 1) | MAG_WIDTH'(mag[0]);
            ex = ex + (EXP_WIDTH+3)'(1);
        end
        else if (top < LZ_WIDTH'(GRS - 1))
        begin
            lsh = LZ_WIDTH'(GRS - 1) - top;
            nm = mag << lsh;
            ex = ex - (EXP_WIDTH+3)'(lsh);
        end
        mant = (FRAC_WIDTH+2)'(nm >> 3);
        rnd = nm[2] && (nm[1] || nm[0] || mant[0]);
        mant = mant + (FRAC_WIDTH+2)'(rnd);
        if (mant[FRAC_WIDTH+1])
        begin
            mant = mant >> 1;
            ex = ex + (EXP_WIDTH+3)'(1);
        end

        if ((ea == EMAX && fa != '0) || (eb == EMAX && fb != '0)
            || (ea == EMAX && eb == EMAX && sa != sb))
            res_next = {sa & sb, EMAX, FONES};
        else if (ea == EMAX)
            res_next = {sa, EMAX, {FRAC_WIDTH{1'b0}}};
        else if (eb == EMAX)
            res_next = {sb, EMAX, {FRAC_WIDTH{1'b0}}};
        else if (ea == '0 && eb == '0)
            res_next = {sa & sb, {(FMT_WIDTH-1){1'b0}}};
        else if (ea == '0)
            res_next = b_reg;
        else if (eb == '0)
            res_next = a_reg;
        else if (mag == '0)
            res_next = '0;
        else if (ex <= 0)
            res_next = {xs, {(FMT_WIDTH-1){1'b0}}};
        else if (ex >= (EXP_WIDTH+3)'(EMAX))
            res_next = {xs, EMAX, {FRAC_WIDTH{1'b0}}};
        else
            res_next = {xs, EXP_WIDTH'(ex), mant[FRAC_WIDTH-1:0]};
    end
endmodule
`default_nettype wire

// ----- rtl/core/fp32_adder_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_adder_checker: port-level checks
// Bound to the adder top level.
// ----------------------------------------------------------------------------
module fp32_adder_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] sum
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum)) else $error("result dropped");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready) else $error("stall without backpressure");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
        else $error("item lost");
endmodule

bind fp32_adder fp32_adder_checker u_chk (.*);
`default_nettype wire

// ----- bench/fp32_adder_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_adder_check: sum predictor and scoreboard for the binary32 adder
// Watches both handshakes, computes the expected rounded sum of each accepted
// operand pair and compares it with the sums leaving the block, in order.
// ----------------------------------------------------------------------------
module fp32_adder_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [fpa_pkg::FMT_WIDTH-1:0] operand_a,
    input  logic [fpa_pkg::FMT_WIDTH-1:0] operand_b,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fpa_pkg::FMT_WIDTH-1:0] sum,
    output int                            errors,
    output int                            pending
);
    import fpa_pkg::*;

    localparam logic [EXP_WIDTH-1:0]  EMAX  = '1;
    localparam logic [FRAC_WIDTH-1:0] FONES = '1;

    logic [FMT_WIDTH-1:0] sum_queue [$];

    function automatic logic [FMT_WIDTH-1:0] pack(logic s, logic [EXP_WIDTH-1:0] e,
                                                  logic [FRAC_WIDTH-1:0] f);
        return {s, e, f};
    endfunction

    function automatic logic [FMT_WIDTH-1:0] predict_sum(logic [FMT_WIDTH-1:0] a,
                                                         logic [FMT_WIDTH-1:0] b);
        logic                  sa, sb, xs, ys;
        logic [EXP_WIDTH-1:0]  ea, eb, xe, ye;
        logic [FRAC_WIDTH-1:0] fa, fb;
        logic [63:0]           ma, mb, tmp, ysh, mag, mant, diff;
        logic                  stk;
        int                    top, ex;
        sa = a[FMT_WIDTH-1]; sb = b[FMT_WIDTH-1];
        ea = a[FMT_WIDTH-2 -: EXP_WIDTH]; eb = b[FMT_WIDTH-2 -: EXP_WIDTH];
        fa = a[FRAC_WIDTH-1:0]; fb = b[FRAC_WIDTH-1:0];
        if ((ea == EMAX && fa != 0) || (eb == EMAX && fb != 0)
            || (ea == EMAX && eb == EMAX && sa != sb))
            return pack(sa & sb, EMAX, FONES);
        if (ea == EMAX) return pack(sa, EMAX, '0);
        if (eb == EMAX) return pack(sb, EMAX, '0);
        if (ea == 0 && eb == 0) return pack(sa & sb, '0, '0);
        if (ea == 0) return b;
        if (eb == 0) return a;
        ma = (64'd1 << FRAC_WIDTH) | 64'(fa);
        mb = (64'd1 << FRAC_WIDTH) | 64'(fb);
        if (ea > eb || (ea == eb && ma >= mb))
        begin
            xe = ea; ye = eb; xs = sa; ys = sb;
        end
        else
        begin
            tmp = ma; ma = mb; mb = tmp;
            xe = eb; ye = ea; xs = sb; ys = sa;
        end
        diff = 64'(xe - ye);
        if (diff > FRAC_WIDTH + 4) diff = FRAC_WIDTH + 4;
        ma = ma << 3;
        ysh = mb << 3;
        stk = (ysh & ((64'd1 << diff) - 1)) != 0;
        ysh = (ysh >> diff) | 64'(stk);
        mag = (xs == ys) ? ma + ysh : ma - ysh;
        if (mag == 0) return '0;
        top = -1;
        for (int i = FRAC_WIDTH + 4; i >= 0; i--)
            if (mag[i] && top < 0) top = i;
        ex = int'(xe);
        if (top == FRAC_WIDTH + 4)
        begin
            mag = (mag >> 1) | (mag & 1);
            ex++;
        end
        else if (top < FRAC_WIDTH + 3)
        begin
            mag = mag << (FRAC_WIDTH + 3 - top);
            ex -= FRAC_WIDTH + 3 - top;
        end
        mant = mag >> 3;
        if (mag[2] && (mag[1:0] != 0 || mant[0])) mant++;
        if (mant >> (FRAC_WIDTH + 1))
        begin
            mant = mant >> 1;
            ex++;
        end
        if (ex <= 0) return pack(xs, '0, '0);
        if (ex >= int'(EMAX)) return pack(xs, EMAX, '0);
        return pack(xs, EXP_WIDTH'(ex), mant[FRAC_WIDTH-1:0]);
    endfunction

    initial errors = 0;
    assign pending = sum_queue.size();

    always @(posedge clk)
    begin
        logic [FMT_WIDTH-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (sum_queue.size() == 0)
                begin
                    if (errors < 10) $display("unexpected sum %08h", sum);
                    errors <= errors + 1;
                end
                else
                begin
                    want = sum_queue.pop_front();
                    if (want !== sum)
                    begin
                        if (errors < 10) $display("sum: expected %08h got %08h", want, sum);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                sum_queue.push_back(predict_sum(operand_a, operand_b));
        end
    end
endmodule

// ----- bench/fp32_adder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_adder_test: stimulus and verdict for the binary32 adder
// Directed special values, then random operand pairs weighted toward close
// exponents, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module fp32_adder_test;
    import fpa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FMT_WIDTH-1:0] operand_a = '0;
    logic [FMT_WIDTH-1:0] operand_b = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FMT_WIDTH-1:0] sum;
    int                   errors, pending;
    int                   cycles = 0;
    bit                   hold_drain = 1'b0;

    fp32_adder dut (.*);

    fp32_adder_check check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fp32_adder: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        int          k;
        v = $urandom;
        k = $urandom_range(0, 19);
        if (k == 0) v[30:23] = '0;
        else if (k == 1) v[30:23] = '1;
        else if (k == 2) v[22:0] = ($urandom_range(0, 1)) ? '0 : '1;
        return v;
    endfunction

    initial
    begin
        int wait_n;
        repeat (2000)
        begin
            @(posedge clk);
            if (hold_drain)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                wait_n = gap_len();
                out_ready <= 1'b0;
                if (wait_n > 0) repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    task automatic send(logic [31:0] a, logic [31:0] b);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] a, b;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(32'h3f800000, 32'h3f800000);
        send(32'h3f800000, 32'hbf800000);
        send(32'h7f800000, 32'h3f800000);
        send(32'h3f800000, 32'hff800000);
        send(32'h7f800000, 32'hff800000);
        send(32'hff800000, 32'hff800000);
        send(32'h7fc00001, 32'h3f800000);
        send(32'hffffffff, 32'hffffffff);
        send(32'h00000000, 32'h80000000);
        send(32'h80000000, 32'h80000000);
        send(32'h00000000, 32'hc0490fdb);
        send(32'h80000001, 32'h3f800000);
        send(32'h007fffff, 32'h807fffff);
        send(32'h7f7fffff, 32'h7f7fffff);
        send(32'h00800000, 32'h80800001);
        send(32'h00800001, 32'h80800000);
        send(32'h3f800000, 32'h33800000);
        send(32'h3f800001, 32'h33800000);
        send(32'h3f800000, 32'h33800001);
        send(32'h4b800000, 32'h00800000);
        send(32'h3f800000, 32'hbf7fffff);
        send(32'h7f000000, 32'h7f000000);
        send(32'h55555555, 32'haaaaaaaa);
        hold_drain = 1'b1;
        for (int n = 0; n < 1030; n++)
        begin
            if (n == 60) hold_drain = 1'b0;
            if (n == 500)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            a = rand_fp();
            b = rand_fp();
            if ($urandom_range(0, 3) != 0)
            begin
                b[30:23] = a[30:23] + 8'($urandom_range(0, 6)) - 8'd3;
                if ($urandom_range(0, 1)) b[31] = ~a[31];
                if ($urandom_range(0, 4) == 0) b[22:0] = a[22:0] ^ 23'($urandom_range(0, 7));
            end
            send(a, b);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("fp32_adder: match");
        else
            $display("fp32_adder: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/fpa_pkg.sv
rtl/core/fp32_adder.sv
rtl/core/fp32_adder_checker.sv
bench/fp32_adder_check.sv
bench/fp32_adder_test.sv
